// ----- rtl/ordered_list_engine_macros.svh -----
// assertion macros for the ordered list engine
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define OLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OLE_ASSERT_NOW(lbl, ante, cons, msg)
`define OLE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/ole_pkg.sv -----
// shared types and constants of the ordered list engine
// no dependencies; used by the interfaces, the cell and the top level
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 3;
  localparam int TOT_W    = 9;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_SEARCH    = 3'd3,
    ACT_OVERWRITE = 3'd4
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_WRITE
  } cell_op_t;

endpackage

// ----- rtl/ole_if.sv -----
// request and result channel interfaces of the ordered list engine
// depends on ole_pkg for field widths
interface ole_in_if;
  import ole_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface ole_out_if;
  import ole_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] found_index;
  logic [TOT_W-1:0] entry_total;

  modport source (output valid, output status, output found_index, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input found_index, input entry_total,
                  output ready);
endinterface

// ----- rtl/ole_cell.sv -----
// one list slot: holds a value, shifts with its neighbors, compares with the key
// depends on ole_pkg
module ole_cell (
  input  logic             clk,
  input  ole_pkg::cell_op_t op,
  input  ole_pkg::val_t    left_val,
  input  ole_pkg::val_t    right_val,
  input  ole_pkg::val_t    wr_val,
  input  ole_pkg::val_t    key,
  output ole_pkg::val_t    val,
  output logic             match
);
  import ole_pkg::*;

  val_t val_r, val_nxt;

  always_comb begin
    case (op)
      CELL_SHIFT_IN:  val_nxt = left_val;
      CELL_SHIFT_OUT: val_nxt = right_val;
      CELL_WRITE:     val_nxt = wr_val;
      default:        val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign match = (val_r == key);

endmodule

// ----- rtl/ordered_list_engine.sv -----
// ordered list engine: bounded list of signed values held in a row of cells
// a result is registered in the cycle after its request beat is taken
// throughput: one request per cycle; all cells shift or compare in the accept cycle,
//   and a new beat is taken whenever the result register is empty or being drained
// reset: entry count and result valid clear; cell contents are not cleared
module ordered_list_engine (
  input logic    clk,
  input logic    rst_n,
  ole_in_if.sink   in_ch,
  ole_out_if.source out_ch
);
  import ole_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [POS_W-1:0] found_r, found_nxt;

  logic     accept;
  action_t  act;
  logic     full;
  logic     pos_ok;
  logic     do_front, do_back, do_del, do_wr;

  val_t                cell_val [CAPACITY];
  logic [CAPACITY-1:0] match_vec, hit_vec;
  cell_op_t            cell_op  [CAPACITY];
  logic [IDX_W-1:0]    hit_idx;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign act         = action_t'(in_ch.action);
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign pos_ok      = ({1'b0, in_ch.position} < TOT_W'(count_r));

  // first live cell that matches the key
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IDX_W'(i);
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = '0;
    count_nxt  = count_r;
    do_front   = 1'b0;
    do_back    = 1'b0;
    do_del     = 1'b0;
    do_wr      = 1'b0;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_front  = (act == ACT_INS_FRONT);
          do_back   = (act == ACT_INS_BACK);
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!pos_ok) begin
          status_nxt = ST_INVALID;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_SEARCH: begin
        if (|hit_vec) begin
          found_nxt = POS_W'(hit_idx);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      ACT_OVERWRITE: begin
        if (!pos_ok) status_nxt = ST_INVALID;
        else         do_wr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    val_t left_val, right_val;

    if (i == 0) begin : g_head
      assign left_val = val_t'(in_ch.value);
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    assign hit_vec[i] = match_vec[i] && (CNT_W'(i) < count_r);

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (accept) begin
        if (do_front) begin
          cell_op[i] = CELL_SHIFT_IN;
        end else if (do_back && (count_r == CNT_W'(i))) begin
          cell_op[i] = CELL_WRITE;
        end else if (do_del && (TOT_W'(i) >= {1'b0, in_ch.position})) begin
          cell_op[i] = CELL_SHIFT_OUT;
        end else if (do_wr && (TOT_W'(i) == {1'b0, in_ch.position})) begin
          cell_op[i] = CELL_WRITE;
        end
      end
    end

    ole_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .left_val  (left_val),
      .right_val (right_val),
      .wr_val    (val_t'(in_ch.value)),
      .key       (val_t'(in_ch.value)),
      .val       (cell_val[i]),
      .match     (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.found_index = found_r;
  assign out_ch.entry_total = TOT_W'(count_r);

  // entry_total reads the live count; it only moves on a new beat, which needs
  // the result register free, so it matches the held result

`include "ordered_list_engine_macros.svh"

  `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY),
                  "count above capacity")
  `OLE_ASSERT_NXT(a_full_holds, accept && full && (act == ACT_INS_FRONT || act == ACT_INS_BACK),
                  count_r == $past(count_r), "insert on full list changed count")
  `OLE_ASSERT_NXT(a_delete_dec, accept && do_del, count_r == $past(count_r) - 1'b1,
                  "delete did not shrink list")
  `OLE_ASSERT_NOW(a_full_status, out_valid_r && status_r == ST_FULL,
                  count_r == CNT_W'(CAPACITY), "full status with room left")

endmodule

// ----- tb/tb_ordered_list_engine.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the ordered list engine: directed and random requests,
// random idling on both channels; depends on ole_pkg, ole_if.sv and ordered_list_engine.sv
import ole_pkg::*;

typedef struct packed {
  status_t          status;
  logic [POS_W-1:0] found_index;
  logic [TOT_W-1:0] entry_total;
} list_result_t;

class list_scoreboard;
  val_t         cells[CAPACITY];
  int unsigned  count;
  list_result_t pending[$];
  int unsigned  errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  // updates the mirror of the list and queues the result the beat must give
  function void note_request(logic [ACT_W-1:0] act, val_t val, logic [POS_W-1:0] pos);
    list_result_t res;
    res.status      = ST_OK;
    res.found_index = '0;
    case (act)
      ACT_INS_FRONT: begin
        if (count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = count; i > 0; i--) cells[i] = cells[i-1];
          cells[0] = val;
          count++;
        end
      end
      ACT_INS_BACK: begin
        if (count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          cells[count] = val;
          count++;
        end
      end
      ACT_DELETE: begin
        if (count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= count) begin
          res.status = ST_INVALID;
        end else begin
          for (int i = pos; i < count - 1; i++) cells[i] = cells[i+1];
          count--;
        end
      end
      ACT_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < count; i++) begin
          if (cells[i] == val) begin
            res.status      = ST_OK;
            res.found_index = i[POS_W-1:0];
            break;
          end
        end
      end
      ACT_OVERWRITE: begin
        if (pos >= count) res.status = ST_INVALID;
        else cells[pos] = val;
      end
      default: ;  // unused codes leave the list alone
    endcase
    res.entry_total = count[TOT_W-1:0];
    pending.push_back(res);
  endfunction

  function void check_result(logic [ST_W-1:0] status, logic [POS_W-1:0] found_index,
                             logic [TOT_W-1:0] entry_total);
    list_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: result beat with no request pending, actual status %0d index %0d total %0d",
               $time, status, found_index, entry_total);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
      errors++;
    end
    if (found_index !== want.found_index) begin
      $display("%0t: found_index mismatch, expected %0d, actual %0d",
               $time, want.found_index, found_index);
      errors++;
    end
    if (entry_total !== want.entry_total) begin
      $display("%0t: entry_total mismatch, expected %0d, actual %0d",
               $time, want.entry_total, entry_total);
      errors++;
    end
  endfunction
endclass

module tb_ordered_list_engine;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned QUIET_FROM   = 520;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI  = 3'd7;
  localparam val_t VAL_MAX = 32'sh7fff_ffff;
  localparam val_t VAL_MIN = 32'sh8000_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          quiet = 1'b0;
  int unsigned cycles = 0;

  list_scoreboard sb = new();

  ole_in_if  in_ch();
  ole_out_if out_ch();

  ordered_list_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.found_index, out_ch.entry_total);
  end

  // result side: ready bursts low now and then, with long open stretches
  initial begin : result_sink
    int unsigned hold;
    out_ch.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      out_ch.ready = 1'b1;
      hold = $urandom_range(1, 40);
      if ($urandom_range(0, 9) == 0) hold = 200;
      repeat (hold) @(negedge clk);
      if (!quiet) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end
    end
  end

  task automatic pause_sender(int unsigned n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // one request beat, with a random gap ahead of it unless the run is in its quiet part
  task automatic issue(logic [ACT_W-1:0] act, val_t val, logic [POS_W-1:0] pos);
    if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 18));
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.action   = act;
    in_ch.value    = val;
    in_ch.position = pos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(act, val, pos);
  endtask

  function automatic val_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $signed($urandom_range(0, 8)) - 4;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return POS_W'($urandom_range(0, 255));
    if (r == 1) return POS_W'(sb.count + $urandom_range(0, 3));
    return POS_W'($urandom_range(0, sb.count));
  endfunction

  initial begin : stimulus
    int unsigned      done;
    int unsigned      r;
    int unsigned      ins_w;
    int unsigned      del_w;
    bit               filling;
    logic [ACT_W-1:0] act;
    val_t             val;

    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_INS_FRONT;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list corner cases
    issue(ACT_SEARCH, '0, '0);
    issue(ACT_DELETE, '0, '0);
    issue(ACT_OVERWRITE, VAL_MAX, '0);
    issue(ACT_UNUSED_LO, VAL_MIN, 8'hff);
    // extremes of the value field
    issue(ACT_INS_BACK, VAL_MAX, '0);
    issue(ACT_INS_FRONT, VAL_MIN, 8'hff);
    issue(ACT_INS_BACK, '0, '0);
    issue(ACT_INS_BACK, -1, '0);
    issue(ACT_SEARCH, -1, '0);
    issue(ACT_SEARCH, VAL_MIN, '0);
    issue(ACT_OVERWRITE, 5, 8'hff);
    // duplicate key: search must report the first position
    issue(ACT_OVERWRITE, VAL_MIN, 8'd1);
    issue(ACT_SEARCH, VAL_MIN, '0);
    for (int i = 0; i < CAPACITY - 4; i++) issue(ACT_INS_BACK, i * 7 - 3, '0);
    // full list
    issue(ACT_INS_FRONT, 42, '0);
    issue(ACT_INS_BACK, 42, '0);
    issue(ACT_SEARCH, (CAPACITY - 5) * 7 - 3, '0);
    issue(ACT_DELETE, '0, POS_W'(CAPACITY));
    issue(ACT_DELETE, '0, POS_W'(CAPACITY - 1));
    issue(ACT_DELETE, '0, '0);
    issue(ACT_UNUSED_HI, 1, 8'd1);
    issue(ACT_UNUSED_MID, -1, 8'd3);

    done    = 0;
    filling = 1'b1;
    while (done < RANDOM_ITEMS) begin
      if (done >= QUIET_FROM) quiet = 1'b1;
      if (done == RANDOM_ITEMS / 2) begin
        // hold the sender until every outstanding result has drained
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      // swing the list between empty and full
      if (sb.count >= CAPACITY && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (sb.count == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      ins_w = filling ? 45 : 15;
      del_w = filling ? 15 : 45;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // unused codes: not counted
        issue(ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), $urandom,
              POS_W'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, ins_w + del_w + 37);
        val = pick_value();
        if (r < ins_w) begin
          act = $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_BACK;
        end else if (r < ins_w + del_w) begin
          act = ACT_DELETE;
        end else if (r < ins_w + del_w + 20) begin
          act = ACT_SEARCH;
          if (sb.count > 0 && $urandom_range(0, 9) < 6)
            val = sb.cells[$urandom_range(0, sb.count - 1)];
        end else begin
          act = ACT_OVERWRITE;
        end
        issue(act, val, pick_position());
        done++;
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
